FILE: rtl/core/jsam_pkg.sv
// Shared types, constants and a helper function of the joystick axis smoothing and map unit.
// Used by the configuration block, the lanes, the divider and the top level.
package jsam_pkg;

    localparam int SMP_W = 12;
    localparam int OUT_W = 16;
    localparam int NUM_W = 31;
    localparam int DEN_W = 14;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int LANES = 3;

    localparam logic [2:0] REG_RES_MODE = 3'd0;
    localparam logic [2:0] REG_SOFTNESS = 3'd1;
    localparam logic [2:0] REG_X_OFFSET = 3'd2;
    localparam logic [2:0] REG_Y_OFFSET = 3'd3;
    localparam logic [2:0] REG_Z_OFFSET = 3'd4;
    localparam logic [2:0] REG_MAP_LOW = 3'd5;
    localparam logic [2:0] REG_MAP_HIGH = 3'd6;

    typedef struct packed {
        logic [11:0] x_sample;
        logic [11:0] y_sample;
        logic [11:0] z_sample;
    } t_in;

    typedef struct packed {
        logic signed [15:0] x_out;
        logic signed [15:0] y_out;
        logic signed [15:0] z_out;
        logic               divide_fault;
    } t_out;

    typedef struct packed {
        logic               res_mode;
        logic [8:0]         softness;
        logic signed [11:0] x_offset;
        logic signed [11:0] y_offset;
        logic signed [11:0] z_offset;
        logic signed [15:0] map_low;
        logic [14:0]        map_high;
    } t_cfg;

    typedef struct packed {
        logic               res_mode;
        logic [8:0]         softness;
        logic signed [11:0] offset;
        logic signed [15:0] map_low;
        logic [14:0]        map_high;
    } t_lane_cfg;

    function automatic logic signed [OUT_W-1:0] sat16(input logic signed [31:0] val);
        logic signed [OUT_W-1:0] res;
        if (val > 32'sd32767) begin
            res = 16'sh7FFF;
        end else if (val < -32'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = val[OUT_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/jsam_cfg.sv
// APB-style configuration register block of the joystick axis unit.
// Depends on jsam_pkg for the register index codes and the t_cfg struct.
module jsam_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [jsam_pkg::ADDR_W-1:0]  paddr,
    input  logic [jsam_pkg::DATA_W-1:0]  pwdata,
    output logic [jsam_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output jsam_pkg::t_cfg               o_cfg
);
    import jsam_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] w_index;
    logic       w_write;

    assign w_index = paddr[4:2];
    assign w_write = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.res_mode <= 1'b1;
            r_cfg.softness <= '0;
            r_cfg.x_offset <= '0;
            r_cfg.y_offset <= '0;
            r_cfg.z_offset <= '0;
            r_cfg.map_low  <= 16'shFE00;
            r_cfg.map_high <= 15'd511;
        end else if (w_write) begin
            unique case (w_index)
                REG_RES_MODE: r_cfg.res_mode <= pwdata[0];
                REG_SOFTNESS: r_cfg.softness <= pwdata[8:0];
                REG_X_OFFSET: r_cfg.x_offset <= pwdata[11:0];
                REG_Y_OFFSET: r_cfg.y_offset <= pwdata[11:0];
                REG_Z_OFFSET: r_cfg.z_offset <= pwdata[11:0];
                REG_MAP_LOW:  r_cfg.map_low  <= pwdata[15:0];
                REG_MAP_HIGH: r_cfg.map_high <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_index)
            REG_RES_MODE: prdata = {31'd0, r_cfg.res_mode};
            REG_SOFTNESS: prdata = {23'd0, r_cfg.softness};
            REG_X_OFFSET: prdata = {20'd0, r_cfg.x_offset};
            REG_Y_OFFSET: prdata = {20'd0, r_cfg.y_offset};
            REG_Z_OFFSET: prdata = {20'd0, r_cfg.z_offset};
            REG_MAP_LOW:  prdata = {16'd0, r_cfg.map_low};
            REG_MAP_HIGH: prdata = {17'd0, r_cfg.map_high};
            default:      prdata = '0;
        endcase
    end

endmodule

FILE: rtl/core/jsam_div.sv
// Sequential signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on jsam_pkg for the numerator and denominator widths.
module jsam_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [jsam_pkg::NUM_W-1:0]  i_num,
    input  logic signed [jsam_pkg::DEN_W-1:0]  i_den,
    output logic                               o_done,
    output logic signed [jsam_pkg::NUM_W-1:0]  o_quo
);
    import jsam_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W:0]   r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_dmag;
    logic             r_neg;

    logic [DEN_W:0]   w_shift;
    logic [DEN_W+1:0] w_trial;

    assign w_shift = {r_rem[DEN_W-1:0], r_quo[NUM_W-1]};
    assign w_trial = {1'b0, w_shift} - {2'b00, r_dmag};
    assign o_done  = r_done;
    assign o_quo   = r_neg ? -$signed(r_quo) : $signed(r_quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo  <= i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
            r_dmag <= i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);
            r_neg  <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
            r_rem  <= '0;
        end else if (r_busy) begin
            if (!w_trial[DEN_W+1]) begin
                r_rem <= w_trial[DEN_W:0];
                r_quo <= {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift;
                r_quo <= {r_quo[NUM_W-2:0], 1'b0};
            end
        end
    end

endmodule

FILE: rtl/core/jsam_lane.sv
// One axis lane: offset removal, exponential smoothing, segment select and mapping.
// Depends on jsam_pkg and instantiates jsam_div for the mapping division.
module jsam_lane #(
    parameter int SAMPLE_BITS = 12,
    parameter int FRAC_BITS   = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [jsam_pkg::SMP_W-1:0]         i_sample,
    input  jsam_pkg::t_lane_cfg                i_cfg,
    input  logic                               i_ack,
    output logic                               o_done,
    output logic signed [jsam_pkg::OUT_W-1:0]  o_result,
    output logic                               o_fault
);
    import jsam_pkg::*;

    localparam int STATE_W = 15 + FRAC_BITS;
    localparam int SUM_W   = STATE_W + 11;
    localparam int USED    = (SAMPLE_BITS < SMP_W) ? SAMPLE_BITS : SMP_W;
    localparam logic [SMP_W-1:0] MASK = SMP_W'((64'd1 << USED) - 64'd1);
    localparam logic signed [SUM_W-1:0] SMAX = SUM_W'((64'sd1 <<< (STATE_W - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SMIN = -SMAX - SUM_W'(1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_MUL    = 7'b0000010,
        S_SUM    = 7'b0000100,
        S_MAP    = 7'b0001000,
        S_LAUNCH = 7'b0010000,
        S_DIV    = 7'b0100000,
        S_FIN    = 7'b1000000
    } t_fsm;

    t_fsm                      r_fsm, n_fsm;
    logic [SMP_W-1:0]          r_sample;
    logic signed [STATE_W-1:0] r_state;
    logic signed [23:0]        r_p1;
    logic signed [STATE_W+9:0] r_p2;
    logic                      r_upper;
    logic signed [NUM_W-1:0]   r_num;
    logic signed [DEN_W-1:0]   r_den;
    logic signed [OUT_W-1:0]   r_result;
    logic                      r_fault;

    logic [8:0]                w_soft;
    logic [8:0]                w_keep;
    logic signed [13:0]        w_off;
    logic signed [13:0]        w_diff;
    logic signed [13:0]        w_half;
    logic signed [SUM_W-1:0]   w_sum;
    logic signed [SUM_W-1:0]   w_floor;
    logic signed [SUM_W-1:0]   w_sat;
    logic signed [STATE_W-1:0] w_trunc;
    logic signed [15:0]        w_v;
    logic                      w_upper;
    logic signed [15:0]        w_a;
    logic signed [16:0]        w_b;
    logic signed [32:0]        w_prod;
    logic signed [31:0]        w_qsum;
    logic                      w_div_done;
    logic signed [NUM_W-1:0]   w_quo;

    assign w_soft  = (i_cfg.softness > 9'd256) ? 9'd256 : i_cfg.softness;
    assign w_keep  = 9'd256 - w_soft;
    assign w_off   = 14'(i_cfg.offset);
    assign w_diff  = $signed({2'b00, r_sample}) - w_off;
    assign w_half  = i_cfg.res_mode ? 14'sd2048 : 14'sd512;

    assign w_sum   = (SUM_W'(r_p1) <<< FRAC_BITS) + SUM_W'(r_p2);
    assign w_floor = w_sum >>> 8;
    assign w_sat   = (w_floor > SMAX) ? SMAX : ((w_floor < SMIN) ? SMIN : w_floor);

    assign w_trunc = (r_state >>> FRAC_BITS)
                   + $signed(STATE_W'(r_state[STATE_W-1] && (|r_state[FRAC_BITS-1:0])));
    assign w_v     = 16'(w_trunc);
    assign w_upper = r_state >= (STATE_W'(w_half) <<< FRAC_BITS);
    assign w_a     = w_upper ? (w_v - 16'(w_half)) : (w_v + 16'(w_off));
    assign w_b     = w_upper ? $signed({2'b00, i_cfg.map_high}) : -(17'(i_cfg.map_low));
    assign w_prod  = w_a * w_b;

    assign w_qsum  = 32'(w_quo) + (r_upper ? 32'sd0 : 32'(i_cfg.map_low));

    assign o_done   = (r_fsm == S_FIN);
    assign o_result = r_result;
    assign o_fault  = r_fault;

    jsam_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_fsm == S_LAUNCH),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_comb begin
        n_fsm = r_fsm;
        unique case (r_fsm)
            S_IDLE:   if (i_start) n_fsm = S_MUL;
            S_MUL:    n_fsm = S_SUM;
            S_SUM:    n_fsm = S_MAP;
            S_MAP:    n_fsm = S_LAUNCH;
            S_LAUNCH: n_fsm = S_DIV;
            S_DIV:    if (w_div_done) n_fsm = S_FIN;
            S_FIN:    if (i_ack) n_fsm = S_IDLE;
            default:  n_fsm = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm   <= S_IDLE;
            r_state <= '0;
        end else begin
            r_fsm <= n_fsm;
            if (r_fsm == S_SUM) begin
                r_state <= STATE_W'(w_sat);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_fsm == S_IDLE && i_start) begin
            r_sample <= i_sample & MASK;
        end
        if (r_fsm == S_MUL) begin
            r_p1 <= w_diff * $signed({1'b0, w_keep});
            r_p2 <= r_state * $signed({1'b0, w_soft});
        end
        if (r_fsm == S_MAP) begin
            r_upper <= w_upper;
            r_num   <= NUM_W'(w_prod);
            r_den   <= w_upper ? (w_half - w_off) : (w_half + w_off);
        end
        if (r_fsm == S_DIV && w_div_done) begin
            if (r_den == '0) begin
                r_result <= '0;
                r_fault  <= 1'b1;
            end else begin
                r_result <= sat16(w_qsum);
                r_fault  <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/core/joystick_axis_smooth_and_map_unit.sv
// An accepted input runs through each lane's multiply, sum, map, launch, divide and finish states.
// The three axis lanes run side by side, each with its own 31-step divider, and a new item enters
// once the result is handed on.
// The result register lets the next item be accepted while a result still waits.
// Reset is synchronous and active low; it restores register defaults and clears filter state.
module joystick_axis_smooth_and_map_unit #(
    parameter int SAMPLE_BITS = 12,
    parameter int FRAC_BITS   = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  jsam_pkg::t_in                i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output jsam_pkg::t_out               o_out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [jsam_pkg::ADDR_W-1:0]  paddr,
    input  logic [jsam_pkg::DATA_W-1:0]  pwdata,
    output logic [jsam_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import jsam_pkg::*;

    t_cfg                    w_cfg;
    t_lane_cfg               w_lcfg   [LANES];
    logic [SMP_W-1:0]        w_smp    [LANES];
    logic                    w_done   [LANES];
    logic signed [OUT_W-1:0] w_res    [LANES];
    logic                    w_fault  [LANES];
    logic                    w_start;
    logic                    w_all_done;
    logic                    w_ack;
    logic                    r_busy;
    logic                    r_out_valid;
    t_out                    r_out;

    jsam_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            w_lcfg[i].res_mode = w_cfg.res_mode;
            w_lcfg[i].softness = w_cfg.softness;
            w_lcfg[i].map_low  = w_cfg.map_low;
            w_lcfg[i].map_high = w_cfg.map_high;
        end
        w_lcfg[0].offset = w_cfg.x_offset;
        w_lcfg[1].offset = w_cfg.y_offset;
        w_lcfg[2].offset = w_cfg.z_offset;
        w_smp[0] = i_in_data.x_sample;
        w_smp[1] = i_in_data.y_sample;
        w_smp[2] = i_in_data.z_sample;
    end

    assign o_in_ready  = !r_busy;
    assign w_start     = i_in_valid & !r_busy;
    assign w_all_done  = w_done[0] & w_done[1] & w_done[2];
    assign w_ack       = r_busy & w_all_done & (!r_out_valid | i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        jsam_lane #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .FRAC_BITS   (FRAC_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_start  (w_start),
            .i_sample (w_smp[g]),
            .i_cfg    (w_lcfg[g]),
            .i_ack    (w_ack),
            .o_done   (w_done[g]),
            .o_result (w_res[g]),
            .o_fault  (w_fault[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_start) begin
                r_busy <= 1'b1;
            end else if (w_ack) begin
                r_busy <= 1'b0;
            end
            if (w_ack) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ack) begin
            r_out.x_out        <= w_res[0];
            r_out.y_out        <= w_res[1];
            r_out.z_out        <= w_res[2];
            r_out.divide_fault <= w_fault[0] | w_fault[1] | w_fault[2];
        end
    end

endmodule
